### hw/rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants for the LRU stack distance profiler
// Holds the default sizes, the fixed field widths of the stream ports and
// the control bundle that the top level drives into every stack cell.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 32;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF  = 32;

    // Fixed field widths on the ports
    localparam int IN_ADDR_W    = 32;
    localparam int CACHE_SIZE_W = 7;
    localparam int HIT_TOTAL_W  = 32;
    localparam int OUT_TDATA_W  = 40;   // 7 + 32 bits, padded to whole bytes

    // Per-cycle control broadcast to all cells
    typedef struct packed {
        logic access;       // an input request is applied to the stack
        logic clear_valid;  // that request ends the trace: drop every entry
        logic drain;        // counts move one cell toward the head
    } t_cell_ctrl;

endpackage

### hw/rtl/lsd_cell.sv
// ----------------------------------------------------------------------------
// lsd_cell: one position of the LRU stack
// Holds one address, its valid bit and the hit count for this stack depth.
// On an access it compares against the request, takes its upper neighbor's
// entry when the stack shifts through it, and bumps its count on a match.
// During readout the counts shift one cell toward the head per step.
// ----------------------------------------------------------------------------
module lsd_cell #(
    parameter int ADDR_BITS  = lsd_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = lsd_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsd_pkg::t_cell_ctrl   i_ctrl,
    input  logic [ADDR_BITS-1:0]  i_addr,      // address of the current request
    input  logic [ADDR_BITS-1:0]  i_up_addr,   // entry of the cell nearer the head
    input  logic                  i_up_valid,
    input  logic                  i_shift_en,  // no match above this cell
    input  logic [COUNT_BITS-1:0] i_dn_count,  // count of the cell further down
    output logic                  o_match,
    output logic [ADDR_BITS-1:0]  o_addr,
    output logic                  o_valid,
    output logic [COUNT_BITS-1:0] o_count
);

    logic [ADDR_BITS-1:0]  r_addr;
    logic                  r_valid;
    logic [COUNT_BITS-1:0] r_count;

    assign o_match = r_valid && (r_addr == i_addr);
    assign o_addr  = r_addr;
    assign o_valid = r_valid;
    assign o_count = r_count;

    // Valid bit and hit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (i_ctrl.access) begin
            if (i_ctrl.clear_valid) begin
                r_valid <= 1'b0;
            end else if (i_shift_en) begin
                r_valid <= i_up_valid;
            end
            if (o_match && (r_count != {COUNT_BITS{1'b1}})) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
        end else if (i_ctrl.drain) begin
            r_count <= i_dn_count;
        end
    end

    // Address payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.access && i_shift_en) begin
            r_addr <= i_up_addr;
        end
    end

endmodule

### hw/rtl/lru_stack_distance_profile.sv
// ----------------------------------------------------------------------------
// lru_stack_distance_profile: LRU stack distance hit curve
// Keeps an LRU stack of recent distinct addresses in a row of cells and a
// hit count per stack depth; on the end-of-trace request it streams out the
// cumulative hit count for every cache size from 1 to STACK_DEPTH.
//
//   port group   dir  tdata                          tuser / tlast
//   s_axis       in   [31:0] address                 tuser[0] end_of_trace
//   m_axis       out  [6:0] cache_size,              tlast final_result
//                     [38:7] hit_total, [39] zero
//
// An ordinary request is taken whenever no readout runs: all cells compare and shift at once.
// An end-of-trace request empties the stack, then the curve leaves at
// one result per cycle while the output is not stalled, set by the count drain
// through the cell row; no request is taken until the last result is registered.
// Output stalls hold the result register and pause the drain.
// Reset (synchronous, active low) empties the stack and zeroes all counts.
// ----------------------------------------------------------------------------
module lru_stack_distance_profile #(
    parameter int STACK_DEPTH = lsd_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_BITS   = lsd_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS  = lsd_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lsd_pkg::IN_ADDR_W-1:0]   i_s_axis_tdata,  // [31:0] address
    input  logic [0:0]                      i_s_axis_tuser,  // [0] end_of_trace
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [lsd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // [6:0] cache_size,
                                                             // [38:7] hit_total
    output logic                            o_m_axis_tlast   // final_result
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Readout state
    logic                               r_busy;
    logic [IDX_W-1:0]                   r_idx;
    logic [COUNT_BITS-1:0]              r_running;
    logic                               r_out_valid;
    logic [lsd_pkg::CACHE_SIZE_W-1:0]   r_out_size;
    logic [lsd_pkg::HIT_TOTAL_W-1:0]    r_out_hit;
    logic                               r_out_last;

    logic                               in_fire;
    logic                               load;
    logic [ADDR_BITS-1:0]               req_addr;
    lsd_pkg::t_cell_ctrl                ctrl;

    logic [STACK_DEPTH-1:0]             match;
    logic [STACK_DEPTH-1:0]             shift_en;
    logic [STACK_DEPTH-1:0]             cell_valid;
    logic [ADDR_BITS-1:0]               cell_addr  [STACK_DEPTH];
    logic [COUNT_BITS-1:0]              cell_count [STACK_DEPTH];

    logic [COUNT_BITS:0]                n_sum;
    logic [COUNT_BITS-1:0]              n_running;
    logic [lsd_pkg::HIT_TOTAL_W-1:0]    shown;
    logic                               idx_last;

    assign o_s_axis_tready = !r_busy;
    assign in_fire         = i_s_axis_tvalid && !r_busy;
    assign load            = r_busy && (!r_out_valid || i_m_axis_tready);

    assign ctrl.access      = in_fire;
    assign ctrl.clear_valid = i_s_axis_tuser[0];
    assign ctrl.drain       = load;

    // Only the low ADDR_BITS of the address take part in the compare
    generate
        if (ADDR_BITS <= lsd_pkg::IN_ADDR_W) begin : g_addr_trunc
            assign req_addr = i_s_axis_tdata[ADDR_BITS-1:0];
        end else begin : g_addr_ext
            assign req_addr = {{(ADDR_BITS-lsd_pkg::IN_ADDR_W){1'b0}}, i_s_axis_tdata};
        end
    endgenerate

    // Row of stack cells; a cell shifts when nothing above it matched
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [ADDR_BITS-1:0]  up_addr;
            logic                  up_valid;
            logic [COUNT_BITS-1:0] dn_count;

            if (gi == 0) begin : g_head
                assign up_addr      = req_addr;
                assign up_valid     = 1'b1;
                assign shift_en[gi] = 1'b1;
            end else begin : g_body
                assign up_addr      = cell_addr[gi-1];
                assign up_valid     = cell_valid[gi-1];
                assign shift_en[gi] = ~|match[gi-1:0];
            end

            if (gi == STACK_DEPTH - 1) begin : g_tail
                assign dn_count = '0;
            end else begin : g_inner
                assign dn_count = cell_count[gi+1];
            end

            lsd_cell #(
                .ADDR_BITS  (ADDR_BITS),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (ctrl),
                .i_addr     (req_addr),
                .i_up_addr  (up_addr),
                .i_up_valid (up_valid),
                .i_shift_en (shift_en[gi]),
                .i_dn_count (dn_count),
                .o_match    (match[gi]),
                .o_addr     (cell_addr[gi]),
                .o_valid    (cell_valid[gi]),
                .o_count    (cell_count[gi])
            );
        end
    endgenerate

    // Saturating running sum of the head cell's count
    assign n_sum     = {1'b0, r_running} + {1'b0, cell_count[0]};
    assign n_running = n_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : n_sum[COUNT_BITS-1:0];
    assign idx_last  = (r_idx == IDX_W'(STACK_DEPTH - 1));

    // Clamp the running sum to the hit_total width
    generate
        if (COUNT_BITS > lsd_pkg::HIT_TOTAL_W) begin : g_clamp
            assign shown = (|n_running[COUNT_BITS-1:lsd_pkg::HIT_TOTAL_W]) ?
                           {lsd_pkg::HIT_TOTAL_W{1'b1}} :
                           n_running[lsd_pkg::HIT_TOTAL_W-1:0];
        end else if (COUNT_BITS == lsd_pkg::HIT_TOTAL_W) begin : g_same
            assign shown = n_running;
        end else begin : g_ext
            assign shown = {{(lsd_pkg::HIT_TOTAL_W-COUNT_BITS){1'b0}}, n_running};
        end
    endgenerate

    // Readout sequencing and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire && i_s_axis_tuser[0]) begin
                r_busy    <= 1'b1;
                r_idx     <= '0;
                r_running <= '0;
            end else if (load) begin
                r_running <= n_running;
                r_idx     <= r_idx + IDX_W'(1);
                if (idx_last) begin
                    r_busy <= 1'b0;
                end
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_size <= lsd_pkg::CACHE_SIZE_W'(r_idx) + lsd_pkg::CACHE_SIZE_W'(1);
            r_out_hit  <= shown;
            r_out_last <= idx_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_hit, r_out_size};
    assign o_m_axis_tlast  = r_out_last;

    // Stack entries stay distinct: at most one cell matches a request
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> $onehot0(match))
        else $error("more than one stack cell matched the request");

    // Once readout is done, a result still waiting is the final one
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_busy) |-> o_m_axis_tlast)
        else $error("non-final result pending outside readout");

    // End of trace starts the readout
    a_eot_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tuser[0]) |=> r_busy)
        else $error("end of trace did not start the readout");

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed or was dropped");

endmodule
